// ===== design/fbf_pkg.sv =====
// shared types, constants and round functions of the four-branch feistel cipher
`timescale 1ns / 1ps

package fbf_pkg;

    localparam int BRANCH_W   = 16;
    localparam int BLOCK_W    = 4 * BRANCH_W;
    localparam int KEY_SLOTS  = 128;
    localparam int KEY_IDX_W  = $clog2(KEY_SLOTS);
    localparam int ROUND_W    = 8;
    localparam int MAX_ROUNDS = 128;
    localparam int ROUND_LIMIT = (MAX_ROUNDS < KEY_SLOTS) ? MAX_ROUNDS : KEY_SLOTS;
    localparam int ROT_LEFT   = 9;
    localparam int ROT_RIGHT  = 11;

    localparam int KIND_W     = 2;
    localparam int IN_BITS    = KEY_IDX_W + BRANCH_W + BLOCK_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENCRYPT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DECRYPT = 2'd2;

    typedef logic [BRANCH_W-1:0] branch_t;
    typedef logic [BLOCK_W-1:0]  block_t;

    // control from the sequencer to the round datapath
    typedef struct packed {
        logic load;
        logic step;
        logic decrypt;
    } rnd_cmd_t;

    function automatic branch_t rotl(input branch_t x);
        rotl = (x << ROT_LEFT) | (x >> (BRANCH_W - ROT_LEFT));
    endfunction

    function automatic branch_t rotr(input branch_t x);
        rotr = (x >> ROT_RIGHT) | (x << (BRANCH_W - ROT_RIGHT));
    endfunction

    function automatic branch_t mix(input branch_t x, input branch_t k);
        mix = rotl(x) ^ ~(rotr(k) ^ x);
    endfunction

    function automatic block_t enc_round(input block_t b, input branch_t k);
        branch_t t;
        t = mix(b[0 +: BRANCH_W], k);
        enc_round = {b[0 +: BRANCH_W],
                     t ^ b[3*BRANCH_W +: BRANCH_W],
                     t ^ b[2*BRANCH_W +: BRANCH_W],
                     t ^ b[BRANCH_W +: BRANCH_W]};
    endfunction

    function automatic block_t dec_round(input block_t b, input branch_t k);
        branch_t t;
        t = mix(b[3*BRANCH_W +: BRANCH_W], k);
        dec_round = {t ^ b[2*BRANCH_W +: BRANCH_W],
                     t ^ b[BRANCH_W +: BRANCH_W],
                     t ^ b[0 +: BRANCH_W],
                     b[3*BRANCH_W +: BRANCH_W]};
    endfunction

endpackage

// ===== design/four_branch_feistel_block_cipher.sv =====
// top level of the four-branch feistel block cipher with round key table
`timescale 1ns / 1ps

// channel   direction  contents (lowest bit first)
// s_axis    in         tuser: kind[1:0]; tdata: key_index[6:0], key_value[22:7],
//                      block_in[86:23], zero pad [87]
// m_axis    out        tdata: block_out[63:0]
// cfg       in         data: rounds_in_use[7:0]
//
// a key load writes the key into the table at acceptance
// a block with R rounds: at acceptance the first key read is issued; then R rounds
// run in the busy state (one table read per round, the ram read register overlapped
// with the round logic); then the done state moves the result into the output register
// R is rounds_in_use, saturated at the table depth of 128
// reset clears control only; the key table is undefined until loaded
// a finished block waits in the branch register while the output register is
// still full; no request is taken, key loads included, until it moves on

module four_branch_feistel_block_cipher (
    input  logic                             clk,
    input  logic                             rst_n,
    // request input
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [fbf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // key_index, key_value, block_in
    input  logic [fbf_pkg::KIND_W-1:0]       s_axis_tuser,  // kind
    // result output
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [fbf_pkg::BLOCK_W-1:0]      m_axis_tdata,  // block_out
    // configuration write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fbf_pkg::ROUND_W-1:0]      cfg_data       // rounds_in_use
);

    import fbf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // unpacked request fields
    logic [KEY_IDX_W-1:0] in_key_index;
    branch_t              in_key_value;
    block_t               in_block;
    logic                 in_acc;

    assign in_key_index = s_axis_tdata[0 +: KEY_IDX_W];
    assign in_key_value = s_axis_tdata[KEY_IDX_W +: BRANCH_W];
    assign in_block     = s_axis_tdata[KEY_IDX_W + BRANCH_W +: BLOCK_W];

    // control state
    logic [1:0]           state_reg, state_next;
    logic [ROUND_W-1:0]   rounds_reg, rounds_next;
    logic [KEY_IDX_W-1:0] cnt_reg, cnt_next;
    logic [KEY_IDX_W-1:0] addr_reg, addr_next;
    logic                 decrypt_reg, decrypt_next;
    logic                 out_valid_reg, out_valid_next;
    block_t               out_data_reg, out_data_next;

    // rounds actually run, saturated at the table depth
    logic [ROUND_W-1:0]   eff_rounds;
    logic [ROUND_W-1:0]   eff_m1;
    logic [KEY_IDX_W-1:0] last_idx;

    // key table and round datapath hookup
    logic                 ram_we;
    logic                 ram_re;
    logic [KEY_IDX_W-1:0] ram_raddr;
    branch_t              ram_rdata;
    rnd_cmd_t             cmd;
    block_t               branches;

    logic                 out_free;
    logic                 is_block;

    assign eff_rounds = (rounds_reg > ROUND_W'(ROUND_LIMIT)) ? ROUND_W'(ROUND_LIMIT)
                                                             : rounds_reg;
    assign eff_m1     = eff_rounds - ROUND_W'(1);
    assign last_idx   = eff_m1[KEY_IDX_W-1:0];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign is_block      = (s_axis_tuser == KIND_ENCRYPT) || (s_axis_tuser == KIND_DECRYPT);
    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // key load writes straight into the table at acceptance
    assign ram_we = in_acc && (s_axis_tuser == KIND_LOAD);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        addr_next      = addr_reg;
        decrypt_next   = decrypt_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        rounds_next    = rounds_reg;
        ram_re         = 1'b0;
        ram_raddr      = addr_reg;
        cmd            = '0;
        cmd.decrypt    = decrypt_reg;

        if (cfg_valid && cfg_ready)
        begin
            rounds_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && is_block)
                begin
                    cmd.load     = 1'b1;
                    decrypt_next = (s_axis_tuser == KIND_DECRYPT);
                    cnt_next     = '0;
                    if (eff_rounds == '0)
                    begin
                        // identity: straight to the output hand-off
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // fetch the first key: slot 0 going up, last slot going down
                        ram_re     = 1'b1;
                        ram_raddr  = (s_axis_tuser == KIND_DECRYPT) ? last_idx : '0;
                        addr_next  = ram_raddr;
                        state_next = ST_BUSY;
                    end
                end
            end
            ST_BUSY:
            begin
                cmd.step = 1'b1;
                if (cnt_reg == last_idx)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    // prefetch the key for the next round
                    cnt_next  = cnt_reg + KEY_IDX_W'(1);
                    ram_re    = 1'b1;
                    ram_raddr = decrypt_reg ? addr_reg - KEY_IDX_W'(1)
                                            : addr_reg + KEY_IDX_W'(1);
                    addr_next = ram_raddr;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = branches;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rounds_reg    <= '0;
            cnt_reg       <= '0;
            addr_reg      <= '0;
            decrypt_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rounds_reg    <= rounds_next;
            cnt_reg       <= cnt_next;
            addr_reg      <= addr_next;
            decrypt_reg   <= decrypt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // round key table
    fbf_ram #(
        .WIDTH (16),
        .DEPTH (128)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_key_index),
        .wdata (in_key_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // branch register and round logic
    fbf_round u_round (
        .clk       (clk),
        .cmd       (cmd),
        .block_in  (in_block),
        .round_key (ram_rdata),
        .branches  (branches)
    );

endmodule

// ===== design/fbf_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module fbf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/fbf_round.sv =====
// branch register and one feistel round per cycle
`timescale 1ns / 1ps

module fbf_round (
    input  logic             clk,
    input  fbf_pkg::rnd_cmd_t cmd,
    input  fbf_pkg::block_t  block_in,
    input  fbf_pkg::branch_t round_key,
    output fbf_pkg::block_t  branches
);

    import fbf_pkg::*;

    block_t branch_reg;
    block_t branch_next;

    always_comb
    begin
        branch_next = branch_reg;
        if (cmd.load)
        begin
            branch_next = block_in;
        end
        else if (cmd.step)
        begin
            branch_next = cmd.decrypt ? dec_round(branch_reg, round_key)
                                      : enc_round(branch_reg, round_key);
        end
    end

    always_ff @(posedge clk)
    begin
        branch_reg <= branch_next;
    end

    assign branches = branch_reg;

endmodule
